@@ src/shl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shl_pkg: shared types and constants of the state history log
// Sizes of the history, of the entry fields and of the stream words, plus the
// structs that travel along the cell chain.
// ----------------------------------------------------------------------------
package shl_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int TYPE_BITS     = 4;
  localparam int TIME_BITS     = 32;
  localparam int ACTION_BITS   = 2;

  localparam int IN_FIELD_W  = ACTION_BITS + TYPE_BITS + TIME_BITS;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 1 + TYPE_BITS + TIME_BITS;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_INIT   = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  // One history entry.
  typedef struct packed {
    logic [TYPE_BITS-1:0] typ;
    logic [TIME_BITS-1:0] tim;
  } ent_t;

  // Per-cell shift control.
  typedef struct packed {
    logic load;  // take entry and occupancy from the upstream neighbor
    logic clr;   // drop this cell's entry
  } ctl_t;

  // Query token walking the chain from newest to oldest.
  typedef struct packed {
    logic                 vld;
    logic                 found;
    logic [TYPE_BITS-1:0] typ;
    logic [TIME_BITS-1:0] tim;
  } tok_t;

endpackage

@@ src/shl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shl_cell: one entry of the history chain
// Holds one entry and its occupancy flag, shifts toward the old end on insert,
// and advances the query token by one cell per cycle.
// ----------------------------------------------------------------------------
module shl_cell
  import shl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  ctl_t ctl,
  input  ent_t ent_in,
  input  logic occ_in,
  output ent_t ent_out,
  output logic occ_out,
  input  tok_t tok_in,
  output tok_t tok_out
);

  ent_t ent_r;
  logic occ_r;
  logic occ_nxt;
  tok_t tok_r;
  tok_t tok_nxt;

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.clr) begin
      occ_nxt = 1'b0;
    end else if (ctl.load) begin
      occ_nxt = occ_in;
    end
  end

  // First occupied entry at or before the query time wins; otherwise the
  // last occupied type seen sticks.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && occ_r && !tok_in.found) begin
      tok_nxt.typ   = ent_r.typ;
      tok_nxt.found = (tok_in.tim >= ent_r.tim);
    end
  end

  // Only the valid flag of the token is reset; its payload follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      occ_r     <= occ_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.found <= tok_nxt.found;
    tok_r.typ   <= tok_nxt.typ;
    tok_r.tim   <= tok_nxt.tim;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent_r <= ent_in;
    end
  end

  assign ent_out = ent_r;
  assign occ_out = occ_r;
  assign tok_out = tok_r;

endmodule

@@ src/state_history_log.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_history_log: newest-first history of (type, time) entries
// A chain of entry cells keeps the history; inserts shift the chain by one
// cell, and queries walk a token from the newest cell to the oldest.
// ----------------------------------------------------------------------------
//
//  channel | ports           | direction | payload (tdata, lowest bit first)
//  --------+-----------------+-----------+-----------------------------------
//  input   | in_tvalid/tready| slave     | action, entry_type, entry_time
//  result  | out_tvalid/tready| master   | accepted, result_type, result_time
//
//  Timing: init, update and the unused action write their result straight
//  into the output register, and the next item can follow as soon as that
//  register can take it. A query result reaches the output register once the
//  token has walked one cell per cycle down the whole chain; input is blocked
//  until then.
//  Reset: clears all occupancy flags (empty history) and the token; entries
//  themselves are not cleared.
//  Stalls: the output register holds one result; input is taken while no query is
//  in flight and the register is empty or its result is being transferred in the same cycle.
// ----------------------------------------------------------------------------
module state_history_log
  import shl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // action, entry_type, entry_time
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // accepted, result_type, result_time
);

  // Input fields
  act_t                 in_action;
  logic [TYPE_BITS-1:0] in_type;
  logic [TIME_BITS-1:0] in_time;
  logic                 in_fire;

  assign in_action = act_t'(in_tdata[ACTION_BITS-1:0]);
  assign in_type   = in_tdata[ACTION_BITS +: TYPE_BITS];
  assign in_time   = in_tdata[ACTION_BITS+TYPE_BITS +: TIME_BITS];
  assign in_fire   = in_tvalid && in_tready;

  // Chain wiring: index 0 is fed by this level, index i+1 is cell i's output.
  ent_t                 ent_w [0:HISTORY_DEPTH];
  logic [HISTORY_DEPTH:0] occ_w;
  tok_t                 tok_w [0:HISTORY_DEPTH];
  ctl_t                 ctl_w [0:HISTORY_DEPTH-1];

  // Control state
  logic busy_r, busy_nxt;
  logic out_vld_r, out_vld_nxt;
  logic out_acc_r, out_acc_nxt;
  logic [TYPE_BITS-1:0] out_typ_r, out_typ_nxt;
  logic [TIME_BITS-1:0] out_tim_r, out_tim_nxt;

  logic do_init;
  logic do_upd;
  tok_t tok_last;

  assign tok_last = tok_w[HISTORY_DEPTH];

  // Update is taken only on a non-empty history with a later time and a new
  // type compared to the head cell.
  assign do_init = in_fire && (in_action == ACT_INIT);
  assign do_upd  = in_fire && (in_action == ACT_UPDATE) && occ_w[1]
                   && (in_time > ent_w[1].tim) && (in_type != ent_w[1].typ);

  assign in_tready = !busy_r && (!out_vld_r || out_tready);

  // Head of the chain: new entry, always occupied, and the query token.
  assign ent_w[0].typ = in_type;
  assign ent_w[0].tim = in_time;
  assign occ_w[0]     = 1'b1;

  always_comb begin
    tok_w[0].vld   = in_fire && (in_action == ACT_QUERY);
    tok_w[0].found = 1'b0;
    tok_w[0].typ   = '0;
    tok_w[0].tim   = in_time;
  end

  // Head cell loads on init or accepted update; the rest shift on update
  // and drop their entries on init.
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (i == 0) begin
        ctl_w[i].load = do_init || do_upd;
        ctl_w[i].clr  = 1'b0;
      end else begin
        ctl_w[i].load = do_upd;
        ctl_w[i].clr  = do_init;
      end
    end
  end

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    shl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl_w[g]),
      .ent_in  (ent_w[g]),
      .occ_in  (occ_w[g]),
      .ent_out (ent_w[g+1]),
      .occ_out (occ_w[g+1]),
      .tok_in  (tok_w[g]),
      .tok_out (tok_w[g+1])
    );
  end

  // Busy from query transfer until the token leaves the last cell; the
  // output register takes either a query result or an immediate result.
  always_comb begin
    busy_nxt    = busy_r;
    out_vld_nxt = out_vld_r;
    out_acc_nxt = out_acc_r;
    out_typ_nxt = out_typ_r;
    out_tim_nxt = out_tim_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (tok_last.vld) begin
      busy_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
      out_acc_nxt = 1'b0;
      out_typ_nxt = tok_last.typ;
      out_tim_nxt = tok_last.tim;
    end else if (in_fire) begin
      if (in_action == ACT_QUERY) begin
        busy_nxt = 1'b1;
      end else begin
        out_vld_nxt = 1'b1;
        out_acc_nxt = do_init || do_upd;
        out_typ_nxt = '0;
        out_tim_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_acc_r <= out_acc_nxt;
    out_typ_r <= out_typ_nxt;
    out_tim_r <= out_tim_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'({out_tim_r, out_typ_r, out_acc_r});

  // Checks
  logic [HISTORY_DEPTH-1:0] occ_v;
  logic [HISTORY_DEPTH-1:0] tok_vld_v;

  assign occ_v = occ_w[HISTORY_DEPTH:1];

  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      tok_vld_v[i] = tok_w[i+1].vld;
    end
  end

  // Occupied cells form an unbroken run from the head.
  a_occ_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_v & (occ_v + 1'b1)) == '0)
    else $error("occupancy has a gap");

  // At most one query in flight.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld_v) <= 1)
    else $error("more than one query token in the chain");

  // A query token only exists while busy.
  a_tok_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_vld_v != '0) |-> busy_r)
    else $error("query token without busy");

  // The finished query never overwrites a pending result.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.vld |-> !out_vld_r)
    else $error("query result would overwrite pending output");

  // The history is never changed while a query walks the chain.
  a_hold_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> $stable(occ_v))
    else $error("history changed during query");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the state history log
// Drives actions into the input stream and keeps an independent model of the
// newest-first history. Every result transfer is checked, field by field,
// against the oldest predicted result. The run covers directed corner cases,
// history overflow, a long output stall and random sequences under several
// idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top
  import shl_pkg::*;
();

  // Predicted content of one result transfer.
  typedef struct {
    logic                 accepted;
    logic [TYPE_BITS-1:0] rtype;
    logic [TIME_BITS-1:0] rtime;
  } log_result_t;

  localparam int TYPE_SPAN = 1 << TYPE_BITS;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // action, entry_type, entry_time
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // accepted, result_type, result_time

  // Model of the history: newest entry at index 0.
  ent_t        hist [HISTORY_DEPTH];
  int          hist_count = 0;
  log_result_t result_q [$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  log_result_t got;
  log_result_t want;

  state_history_log dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the history model by one accepted item and return its result.
  function automatic log_result_t history_step(act_t act, logic [TYPE_BITS-1:0] et,
                                               logic [TIME_BITS-1:0] tm);
    log_result_t r;
    int          n;
    bit          found;
    r = '{accepted: 1'b0, rtype: '0, rtime: '0};
    found = 1'b0;
    case (act)
      ACT_INIT: begin
        hist[0].typ = et;
        hist[0].tim = tm;
        hist_count  = 1;
        r.accepted  = 1'b1;
      end
      ACT_UPDATE: begin
        // Take the entry only if it is strictly later and changes the type.
        if (hist_count > 0 && tm > hist[0].tim && et != hist[0].typ) begin
          n = (hist_count >= HISTORY_DEPTH) ? HISTORY_DEPTH - 1 : hist_count;
          for (int i = n; i > 0; i--) hist[i] = hist[i-1];
          hist[0].typ = et;
          hist[0].tim = tm;
          hist_count  = n + 1;
          r.accepted  = 1'b1;
        end
      end
      ACT_QUERY: begin
        // Walk newest to oldest; without a hit the oldest type remains.
        r.rtime = tm;
        for (int i = 0; i < hist_count; i++) begin
          if (!found) begin
            r.rtype = hist[i].typ;
            if (tm >= hist[i].tim) found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then record its prediction.
  task automatic send_item(act_t act, logic [TYPE_BITS-1:0] et, logic [TIME_BITS-1:0] tm);
    log_result_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({tm, et, act});
    do @(posedge clk); while (!in_tready);
    pred     = history_step(act, et, tm);
    result_q = {result_q, pred};
  endtask

  task automatic report_error(string what, logic [TIME_BITS-1:0] exp_v,
                              logic [TIME_BITS-1:0] act_v);
    if (error_count < 10)
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
    error_count++;
  endtask

  // Result side: stall at the requested rate, or hold off for a whole
  // stretch when a test asks for it.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.accepted = out_tdata[0];
      got.rtype    = out_tdata[TYPE_BITS:1];
      got.rtime    = out_tdata[TYPE_BITS+TIME_BITS:TYPE_BITS+1];
      if (result_q.size() == 0) begin
        report_error("unexpected result", '0, TIME_BITS'(out_tdata));
      end else begin
        want = result_q.pop_front();
        if (got.accepted != want.accepted)
          report_error("accepted", TIME_BITS'(want.accepted), TIME_BITS'(got.accepted));
        if (got.rtype != want.rtype)
          report_error("result_type", TIME_BITS'(want.rtype), TIME_BITS'(got.rtype));
        if (got.rtime != want.rtime)
          report_error("result_time", want.rtime, got.rtime);
      end
    end
  end

  // Corner cases: empty history, unused action, equal and wrapped-looking
  // times, extreme field values and the fall-back to the oldest entry.
  task automatic test_directed_cases();
    send_item(ACT_QUERY, '0, '0);
    send_item(ACT_QUERY, '1, '1);
    send_item(ACT_UPDATE, 4'd5, 32'd100);        // empty history: rejected
    send_item(ACT_NONE, '1, '1);
    send_item(ACT_INIT, '0, '0);
    send_item(ACT_UPDATE, '0, 32'd10);           // same type: rejected
    send_item(ACT_UPDATE, 4'd3, '0);             // equal time: rejected
    send_item(ACT_UPDATE, '1, '1);
    send_item(ACT_UPDATE, 4'd1, '1);             // equal time: rejected
    send_item(ACT_QUERY, 4'd7, '0);
    send_item(ACT_QUERY, '0, 32'hFFFF_FFFE);
    send_item(ACT_QUERY, '1, '1);
    send_item(ACT_NONE, '0, '0);
    send_item(ACT_INIT, 4'd9, 32'h8000_0000);
    send_item(ACT_UPDATE, 4'd10, 32'h7FFF_FFFF); // earlier as unsigned
    send_item(ACT_UPDATE, 4'd10, 32'h8000_0001);
    send_item(ACT_QUERY, '0, 32'h7FFF_FFFF);     // before all: oldest type
    send_item(ACT_QUERY, '1, 32'h8000_0000);
    send_item(ACT_QUERY, '0, '1);
    send_item(ACT_NONE, 4'd6, 32'h5555_AAAA);
  endtask

  // Push more entries than the history holds, then probe every third stored
  // time and a time before the oldest one still kept.
  task automatic test_history_wrap();
    logic [TIME_BITS-1:0] tm;
    tm = 32'd1000;
    send_item(ACT_INIT, 4'd0, tm);
    for (int i = 1; i <= HISTORY_DEPTH + 4; i++) begin
      tm += 32'd10;
      send_item(ACT_UPDATE, TYPE_BITS'(i), tm);
    end
    for (int i = 0; i < HISTORY_DEPTH; i += 3) send_item(ACT_QUERY, '0, hist[i].tim);
    send_item(ACT_QUERY, '0, hist[HISTORY_DEPTH-1].tim - 1);
    send_item(ACT_QUERY, '0, '0);
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_req = 300;
    send_item(ACT_INIT, 4'd2, 32'd50);
    for (int i = 0; i < 12; i++) begin
      send_item(ACT_UPDATE, TYPE_BITS'($urandom_range(0, TYPE_SPAN - 1)),
                hist[0].tim + $urandom_range(0, 3));
      send_item(ACT_QUERY, '0, 32'd40 + $urandom_range(0, 60));
    end
  endtask

  // Random traffic: mostly well-formed runs (init, growing updates, queries
  // near stored times) with rejected updates and noise mixed in.
  task automatic run_random_traffic(int n_items, int idle_pct, int stall_pct);
    int                   sent;
    int                   pick;
    int                   idx;
    act_t                 act;
    logic [TYPE_BITS-1:0] et;
    logic [TIME_BITS-1:0] tm;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      et   = TYPE_BITS'($urandom_range(0, TYPE_SPAN - 1));
      if (pick < 8 || (hist_count == 0 && $urandom_range(0, 3) != 0)) begin
        act = ACT_INIT;
        tm  = $urandom() >> $urandom_range(0, 31);
      end else if (pick < 50) begin
        // A different type and a time that is mostly later, so the update is mostly taken.
        act = ACT_UPDATE;
        et  = hist[0].typ + TYPE_BITS'($urandom_range(1, TYPE_SPAN - 1));
        if ($urandom_range(0, 9) == 0) tm = hist[0].tim + ($urandom() >> 4);
        else tm = hist[0].tim + $urandom_range(1, 1000);
      end else if (pick < 85) begin
        act = ACT_QUERY;
        case ($urandom_range(0, 5))
          0: tm = '0;
          1: tm = '1;
          2: tm = $urandom();
          default: begin
            idx = (hist_count > 0) ? $urandom_range(0, hist_count - 1) : 0;
            tm  = hist[idx].tim + TIME_BITS'($urandom_range(0, 2)) - 1;
          end
        endcase
      end else if (pick < 92) begin
        // Same type, or a time that is not later unless the subtraction wraps: rejected.
        act = ACT_UPDATE;
        if ($urandom_range(0, 1) == 0) begin
          et = hist[0].typ;
          tm = hist[0].tim + $urandom_range(1, 100);
        end else begin
          tm = hist[0].tim - $urandom_range(0, 100);
        end
      end else begin
        act = act_t'($urandom_range(0, 3));
        tm  = $urandom();
      end
      send_item(act, et, tm);
      if (act != ACT_NONE) sent++;
    end
  endtask

  task automatic test_random_no_idle();
    run_random_traffic(240, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random_traffic(240, 85, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random_traffic(240, 0, 85);
  endtask

  task automatic test_random_both_idle();
    run_random_traffic(250, 28, 28);
  endtask

  initial begin
    int waited;
    // Start the history model from known entries.
    foreach (hist[i]) hist[i] = '0;
    // Hold reset, then release it away from the rising edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_history_wrap();
    test_output_backpressure();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    @(negedge clk);
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;

    // Drain the outstanding results, then let the query walk settle.
    waited = 0;
    while (result_q.size() > 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (HISTORY_DEPTH * 4) @(posedge clk);
    if (result_q.size() != 0) begin
      if (error_count < 10) $display("%0d results never arrived", result_q.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("PASS state_history_log");
    end else begin
      $display("FAIL state_history_log");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("FAIL state_history_log");
    $finish;
  end

endmodule

@@ state_history_log.f @@
src/shl_pkg.sv
src/shl_cell.sv
src/state_history_log.sv
test/tb_top.sv
